// File: hdl/dpf_pkg.sv
// Shared constants, types and helpers of the duplicate packet filter.
package dpf_pkg;

	localparam int unsigned DPF_HISTORY_DEPTH = 256;
	localparam int unsigned DPF_FIELD_W = 8;
	localparam int unsigned DPF_KEY_W = 3 * DPF_FIELD_W;

	typedef logic [DPF_FIELD_W-1:0] dpf_field_t;
	typedef logic [DPF_KEY_W-1:0] dpf_key_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} dpf_state_t;

	function automatic dpf_key_t dpf_pack(input dpf_field_t s, input dpf_field_t r,
		input dpf_field_t q);
		return {s, r, q};
	endfunction

endpackage

// File: hdl/duplicate_packet_filter.sv
// Duplicate packet filter: ring history of packet triples scanned from one memory.
//
// Each beat carries one packet triple (sender, receiver, seq). The block reads every
// entry of its history memory, one entry per cycle through its single read port, and
// compares it with the triple. A match reports a duplicate (is_new low) and changes
// nothing; otherwise the triple is written at the ring pointer and is_new is high.
// After acceptance the scan state reads the entries in order, then the finish state
// checks the last one and registers done; busy is low again in the cycle that shows
// done, so a new beat may be started there. The result lasts one cycle and is not
// held: the receiver must take it when done is high. The history counts as all zeros
// after reset without a clearing pass, because entries that were never written are
// tracked by the ring pointer and a wrap flag, so the all-zero triple is a duplicate
// until the whole ring has been filled.
module duplicate_packet_filter
	import dpf_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = DPF_HISTORY_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  dpf_field_t sender,
	input  dpf_field_t receiver,
	input  dpf_field_t seq,
	output logic       done,
	output logic       is_new
);

	localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

	dpf_state_t state_q;
	dpf_key_t key_q;
	logic [AW-1:0] rd_addr_q;
	logic [AW-1:0] wr_ptr_q;
	logic wrapped_q;
	logic match_q;
	logic done_q;
	logic is_new_q;

	dpf_key_t hist_mem [HISTORY_DEPTH];
	dpf_key_t rd_data_s1;
	logic [AW-1:0] addr_s1;
	logic vld_s1;

	logic accept;
	logic entry_written;
	dpf_key_t entry_val;
	logic hit_now;
	logic found;
	logic wr_en;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign is_new = is_new_q;

	// Entries at or above the ring pointer that were never written read as zero.
	assign entry_written = wrapped_q || (addr_s1 < wr_ptr_q);
	assign entry_val = entry_written ? rd_data_s1 : '0;
	assign hit_now = vld_s1 && (entry_val == key_q);
	assign found = match_q || hit_now;
	assign wr_en = (state_q == ST_FINISH) && !found;

	always_ff @(posedge clk) begin
		rd_data_s1 <= hist_mem[rd_addr_q];
		addr_s1 <= rd_addr_q;
		if (wr_en) begin
			hist_mem[wr_ptr_q] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= dpf_pack(sender, receiver, seq);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_addr_q <= '0;
			wr_ptr_q <= '0;
			wrapped_q <= 1'b0;
			match_q <= 1'b0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
			is_new_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_addr_q <= '0;
						match_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					match_q <= found;
					if (rd_addr_q == LAST_ADDR) begin
						state_q <= ST_FINISH;
					end else begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end
				ST_FINISH: begin
					// The last entry's read data is compared in this cycle.
					done_q <= 1'b1;
					is_new_q <= !found;
					if (!found) begin
						if (wr_ptr_q == LAST_ADDR) begin
							wr_ptr_q <= '0;
							wrapped_q <= 1'b1;
						end else begin
							wr_ptr_q <= wr_ptr_q + 1'b1;
						end
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/dpf_checker.sv
// Port-level checks of the duplicate packet filter, bound to its top level.
module dpf_checker
	import dpf_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input dpf_field_t sender,
	input dpf_field_t receiver,
	input dpf_field_t seq,
	input logic       done,
	input logic       is_new
);

	dpf_key_t beat_key;
	assign beat_key = dpf_pack(sender, receiver, seq);

	// An accepted beat raises busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	// A result only follows a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a preceding busy cycle");

	// The result strobe lasts a single cycle.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// Busy ends only when the result is shown, and the result value is known then.
	a_fell_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done && !$isunknown(is_new))
		else $error("busy fell without a result");

	// The sampled beat must be known when it is accepted.
	a_beat_known: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> !$isunknown(beat_key))
		else $error("accepted beat carries unknown bits");

endmodule

bind duplicate_packet_filter dpf_checker u_dpf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.sender(sender),
	.receiver(receiver),
	.seq(seq),
	.done(done),
	.is_new(is_new)
);

// File: sim/tb_duplicate_packet_filter.sv
// Self-checking testbench of the duplicate packet filter with a history-ring scoreboard.

class pkt_history_model;
	dpf_pkg::dpf_key_t ring [dpf_pkg::DPF_HISTORY_DEPTH];
	int unsigned       wr_idx;
	bit                verdicts_due [$];
	int unsigned       n_new;
	int unsigned       n_dup;
	int unsigned       n_wraps;
	int unsigned       n_errors;

	function new();
		foreach (ring[i]) ring[i] = '0;
		wr_idx = 0;
		n_new = 0;
		n_dup = 0;
		n_wraps = 0;
		n_errors = 0;
	endfunction

	// Classifies one accepted triple, records it when it is new and queues the verdict.
	function void note_packet(dpf_pkg::dpf_field_t s, dpf_pkg::dpf_field_t r,
		dpf_pkg::dpf_field_t q);
		dpf_pkg::dpf_key_t key;
		bit                found;
		key = {s, r, q};
		found = 1'b0;
		foreach (ring[i]) begin
			if (ring[i] == key) found = 1'b1;
		end
		if (found) begin
			n_dup++;
		end else begin
			ring[wr_idx] = key;
			if (wr_idx == dpf_pkg::DPF_HISTORY_DEPTH - 1) begin
				wr_idx = 0;
				n_wraps++;
			end else begin
				wr_idx++;
			end
			n_new++;
		end
		verdicts_due.push_back(!found);
	endfunction

	function void check_verdict(logic actual);
		bit want;
		if (verdicts_due.size() == 0) begin
			$display("%0t: done strobe with no packet outstanding, is_new=%b", $time, actual);
			n_errors++;
		end else begin
			want = verdicts_due.pop_front();
			if (actual !== want) begin
				$display("%0t: is_new mismatch, expected %b, actual %b", $time, want, actual);
				n_errors++;
			end
		end
	endfunction

	function int unsigned pending();
		return verdicts_due.size();
	endfunction
endclass

module tb_duplicate_packet_filter;
	import dpf_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	dpf_field_t sender;
	dpf_field_t receiver;
	dpf_field_t seq;
	logic       done;
	logic       is_new;

	pkt_history_model history_sb;
	dpf_key_t         sent_log [$];
	int unsigned      idle_pct;
	int unsigned      phase_idle [3] = '{0, 82, 25};

	// Edge triples, single-byte patterns and repeats that must come back as duplicates.
	dpf_key_t directed_set [18] = '{
		24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
		24'h0000FF, 24'h010000, 24'h000100, 24'h000001, 24'h808080, 24'hAA55AA,
		24'h55AA55, 24'h000000, 24'h010203, 24'h030201, 24'h010203, 24'hFFFFFF
	};

	duplicate_packet_filter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.sender   (sender),
		.receiver (receiver),
		.seq      (seq),
		.done     (done),
		.is_new   (is_new)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#36000000;
		$display("%0t: run did not complete in time", $time);
		$display("[duplicate_packet_filter] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done) history_sb.check_verdict(is_new);
	end

	// Drives one beat and returns at the falling edge after it was taken; start stays high.
	task automatic send_packet(input dpf_field_t s, input dpf_field_t r, input dpf_field_t q);
		start <= 1'b1;
		sender <= s;
		receiver <= r;
		seq <= q;
		@(posedge clk);
		while (busy) @(posedge clk);
		history_sb.note_packet(s, r, q);
		sent_log.push_back({s, r, q});
		if (sent_log.size() > 600) sent_log.delete(0);
		@(negedge clk);
	endtask

	// Start is only lowered when at least one cycle passes, so it never drops and rises in one step.
	task automatic sender_gap();
		int unsigned n;
		bit          after_ready;
		if (idle_pct == 0) return;
		after_ready = ($urandom_range(3) != 0);
		n = 0;
		while (n < 48 && $urandom_range(99) < idle_pct) n++;
		if (!after_ready && n == 0) return;
		start <= 1'b0;
		if (after_ready) begin
			@(posedge clk);
			while (busy) @(posedge clk);
			@(negedge clk);
		end
		repeat (n) @(negedge clk);
	endtask

	task automatic drain_verdicts();
		start <= 1'b0;
		while (history_sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic dpf_field_t tiny_byte();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'h01;
			2: return 8'hFE;
			default: return 8'hFF;
		endcase
	endfunction

	// Mix of fresh triples, recent repeats, repeats from 256 or more beats back that may have
	// left the ring, a crowded small alphabet and the all-zero triple.
	function automatic dpf_key_t pick_triple();
		int unsigned roll;
		int unsigned back;
		int unsigned depth;
		dpf_key_t    k;
		roll = $urandom_range(99);
		depth = sent_log.size();
		if (roll < 30 || depth < 8) begin
			k = dpf_key_t'($urandom_range(24'hFFFFFF, 0));
		end else if (roll < 60) begin
			back = $urandom_range((depth < 150 ? depth : 150) - 1, 0);
			k = sent_log[depth - 1 - back];
		end else if (roll < 75) begin
			if (depth > 300) begin
				back = $urandom_range(depth - 1, 256);
				k = sent_log[depth - 1 - back];
			end else begin
				k = dpf_key_t'($urandom_range(24'hFFFFFF, 0));
			end
		end else if (roll < 94) begin
			k = {tiny_byte(), tiny_byte(), tiny_byte()};
		end else begin
			k = '0;
		end
		return k;
	endfunction

	initial begin
		dpf_key_t    k;
		int unsigned ph;
		int unsigned i;
		history_sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		sender = '0;
		receiver = '0;
		seq = '0;
		idle_pct = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_set[j]) begin
			send_packet(directed_set[j][23:16], directed_set[j][15:8], directed_set[j][7:0]);
		end
		drain_verdicts();

		for (ph = 0; ph < 3; ph++) begin
			idle_pct = phase_idle[ph];
			for (i = 0; i < 584; i++) begin
				k = pick_triple();
				send_packet(k[23:16], k[15:8], k[7:0]);
				sender_gap();
			end
			// The sender holds off here until every verdict has been strobed out.
			drain_verdicts();
		end

		repeat (300) @(posedge clk);
		$display("Covered %0d packet beats: %0d new, %0d duplicates, history ring wrapped %0d times.",
			history_sb.n_new + history_sb.n_dup, history_sb.n_new, history_sb.n_dup,
			history_sb.n_wraps);
		if (history_sb.n_errors == 0) begin
			$display("[duplicate_packet_filter] OK");
		end else begin
			$display("[duplicate_packet_filter] ERROR");
		end
		$finish;
	end

endmodule
